### design/dfst_pkg.sv
// Package: shared types, codes and level tables of the dimmer frame status tracker.
`timescale 1ns / 1ps

package dfst_pkg;

  // Frame kinds
  localparam logic [1:0] KIND_NORMAL  = 2'd0;
  localparam logic [1:0] KIND_MEASURE = 2'd1;
  localparam logic [1:0] KIND_WRITE   = 2'd2;

  // Fixed command codes
  localparam logic [7:0] CODE_OFF        = 8'd0;
  localparam logic [7:0] FIX_TIME_FIRST  = 8'd11;
  localparam logic [7:0] FIX_TIME_LAST   = 8'd18;
  localparam logic [7:0] DIMMER10_MIN    = 8'd2;
  localparam logic [7:0] DIMMER10_MAX    = 8'd10;
  localparam logic [7:0] CODE_LVL_UP     = 8'd30;
  localparam logic [7:0] CODE_LVL_DN     = 8'd31;
  localparam logic [7:0] CODE_PCT_STATUS = 8'd1;
  localparam logic [7:0] ARG_NONE        = 8'd255;
  localparam logic [7:0] STATUS_OFFSET   = 8'd100;
  localparam logic [7:0] STATUS_MAX_ARG  = 8'd200;

  // Argument counts
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  // Level limits
  localparam logic [6:0] LEVEL_MIN = 7'd1;
  localparam logic [6:0] LEVEL_MAX = 7'd100;
  localparam logic [3:0] STEP_MIN  = 4'd2;
  localparam logic [3:0] STEP_MAX  = 4'd10;

  // Level request codes
  localparam logic [1:0] REQ_NONE   = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_CANCEL = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ADVANCED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUNDRED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_CODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMING   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT    = 3'd4;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration reset values
  localparam logic [7:0] ON_CODE_RST     = 8'd1;
  localparam logic [7:0] TIMING_CODE_RST = 8'd2;
  localparam logic [7:0] FAULT_CODE_RST  = 8'd19;

  typedef struct packed {
    logic       advanced_mode;
    logic       hundred_step_mode;
    logic [7:0] on_code;
    logic [7:0] timing_code;
    logic [7:0] fault_code;
  } dfst_cfg_t;

  typedef struct packed {
    logic [6:0] dim_level;
    logic       lamp_on;
  } dfst_state_t;

  typedef struct packed {
    logic [1:0] frame_kind;
    logic [7:0] command_code;
    logic [1:0] arg_count;
    logic [7:0] arg_first;
    logic [7:0] arg_second;
    logic [7:0] arg_third;
    logic       point_to_point;
  } dfst_item_t;

  typedef struct packed {
    logic        on_valid;
    logic        on_value;
    logic        level_valid;
    logic [6:0]  level_value;
    logic        fault_seen;
    logic        timing_valid;
    logic [23:0] timing_hms;
    logic        speed_valid;
    logic [7:0]  speed_value;
    logic [1:0]  level_request;
  } dfst_result_t;

  // Percent level to ten-step level (0 means unknown)
  function automatic logic [3:0] percent_to_ten(input logic [6:0] p);
    logic [3:0] s;
    if (p == 7'd0)       s = 4'd0;
    else if (p <= 7'd4)  s = 4'd2;
    else if (p <= 7'd15) s = 4'd3;
    else if (p <= 7'd25) s = 4'd4;
    else if (p <= 7'd35) s = 4'd5;
    else if (p <= 7'd45) s = 4'd6;
    else if (p <= 7'd53) s = 4'd7;
    else if (p <= 7'd67) s = 4'd8;
    else if (p <= 7'd85) s = 4'd9;
    else                 s = 4'd10;
    return s;
  endfunction

  // Ten-step level to percent
  function automatic logic [6:0] ten_to_percent(input logic [3:0] s);
    logic [6:0] p;
    case (s)
      4'd3:    p = 7'd10;
      4'd4:    p = 7'd20;
      4'd5:    p = 7'd30;
      4'd6:    p = 7'd40;
      4'd7:    p = 7'd50;
      4'd8:    p = 7'd60;
      4'd9:    p = 7'd75;
      4'd0, 4'd1, 4'd2: p = 7'd1;
      default: p = 7'd100;
    endcase
    return p;
  endfunction

  // Rounded ten-step level times ten
  function automatic logic [6:0] ten_times_ten(input logic [3:0] s);
    logic [6:0] v;
    case (s)
      4'd0:    v = 7'd0;
      4'd2:    v = 7'd20;
      4'd3:    v = 7'd30;
      4'd4:    v = 7'd40;
      4'd5:    v = 7'd50;
      4'd6:    v = 7'd60;
      4'd7:    v = 7'd70;
      4'd8:    v = 7'd80;
      4'd9:    v = 7'd90;
      default: v = 7'd100;
    endcase
    return v;
  endfunction

endpackage

### design/dfst_if.sv
// Interfaces: frame input channel and status result channel.
`timescale 1ns / 1ps

interface dfst_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_kind;
  logic [7:0] command_code;
  logic [1:0] arg_count;
  logic [7:0] arg_first;
  logic [7:0] arg_second;
  logic [7:0] arg_third;
  logic       point_to_point;

  modport source (
    output valid, frame_kind, command_code, arg_count, arg_first, arg_second,
           arg_third, point_to_point,
    input  ready
  );
  modport sink (
    input  valid, frame_kind, command_code, arg_count, arg_first, arg_second,
           arg_third, point_to_point,
    output ready
  );
endinterface

interface dfst_out_if;
  logic        valid;
  logic        ready;
  logic        on_valid;
  logic        on_value;
  logic        level_valid;
  logic [6:0]  level_value;
  logic        fault_seen;
  logic        timing_valid;
  logic [23:0] timing_hms;
  logic        speed_valid;
  logic [7:0]  speed_value;
  logic [1:0]  level_request;

  modport source (
    output valid, on_valid, on_value, level_valid, level_value, fault_seen,
           timing_valid, timing_hms, speed_valid, speed_value, level_request,
    input  ready
  );
  modport sink (
    input  valid, on_valid, on_value, level_valid, level_value, fault_seen,
           timing_valid, timing_hms, speed_valid, speed_value, level_request,
    output ready
  );
endinterface

### design/dfst_step.sv
// Frame decode: status result and next dimmer state for one frame.
`timescale 1ns / 1ps

module dfst_step (
  input  dfst_pkg::dfst_item_t   item_i,
  input  dfst_pkg::dfst_cfg_t    cfg_i,
  input  dfst_pkg::dfst_state_t  state_i,
  output dfst_pkg::dfst_result_t result_o,
  output dfst_pkg::dfst_state_t  state_o
);
  import dfst_pkg::*;

  logic              adv, hun, normal, meas_or_write;
  logic              is_onoff, is_on, is_incdec, is_inc, is_ten, is_fixed, all_none;
  logic [3:0]        cur_step;
  logic signed [5:0] step_adj;
  logic [3:0]        step_new;
  logic signed [9:0] delta_adj;
  logic [6:0]        delta_dim;
  logic [6:0]        status_dim;
  logic [7:0]        status_raw;

  logic        on_v, on_val, tm_v, skip_fixed, lv_v, fault, lo, sp_v;
  logic [23:0] tm;
  logic [1:0]  req;
  logic [6:0]  dim;

  // Frame classification
  always_comb begin
    adv           = cfg_i.advanced_mode;
    hun           = cfg_i.advanced_mode & cfg_i.hundred_step_mode;
    normal        = item_i.frame_kind == KIND_NORMAL;
    meas_or_write = (item_i.frame_kind == KIND_MEASURE) ||
                    (item_i.frame_kind == KIND_WRITE);
    is_on         = item_i.command_code == cfg_i.on_code;
    is_onoff      = is_on || (item_i.command_code == CODE_OFF);
    is_inc        = item_i.command_code == CODE_LVL_UP;
    is_incdec     = is_inc || (item_i.command_code == CODE_LVL_DN);
    is_ten        = (item_i.command_code >= DIMMER10_MIN) &&
                    (item_i.command_code <= DIMMER10_MAX);
    is_fixed      = (item_i.command_code >= FIX_TIME_FIRST) &&
                    (item_i.command_code <= FIX_TIME_LAST);
    all_none      = (item_i.arg_first == ARG_NONE) && (item_i.arg_second == ARG_NONE) &&
                    (item_i.arg_third == ARG_NONE);
  end

  // Ten-step increment / decrement, clamped to 2..10
  always_comb begin
    cur_step = percent_to_ten(state_i.dim_level);
    step_adj = $signed({2'b00, cur_step}) + (is_inc ? 6'sd1 : -6'sd1);
    if (step_adj < $signed({2'b00, STEP_MIN}))      step_new = STEP_MIN;
    else if (step_adj > $signed({2'b00, STEP_MAX})) step_new = STEP_MAX;
    else                                            step_new = step_adj[3:0];
  end

  // Percent delta step, clamped to 1..100
  always_comb begin
    if (is_inc) delta_adj = $signed({3'b000, state_i.dim_level}) +
                            $signed({2'b00, item_i.arg_first});
    else        delta_adj = $signed({3'b000, state_i.dim_level}) -
                            $signed({2'b00, item_i.arg_first});
    if (delta_adj < $signed({3'b000, LEVEL_MIN}))      delta_dim = LEVEL_MIN;
    else if (delta_adj > $signed({3'b000, LEVEL_MAX})) delta_dim = LEVEL_MAX;
    else                                               delta_dim = delta_adj[6:0];
  end

  // Percent status argument, level plus 100, clamped to 1..100
  always_comb begin
    status_raw = item_i.arg_first - STATUS_OFFSET;
    if (item_i.arg_first <= STATUS_OFFSET)      status_dim = LEVEL_MIN;
    else if (item_i.arg_first > STATUS_MAX_ARG) status_dim = LEVEL_MAX;
    else                                        status_dim = status_raw[6:0];
  end

  // Status decisions in priority order
  always_comb begin
    on_v       = 1'b0;
    on_val     = 1'b0;
    tm_v       = 1'b0;
    tm         = '0;
    skip_fixed = 1'b0;
    // on/off and variable timing
    if (is_onoff) begin
      if (normal && ((item_i.arg_count == CNT_NONE) ||
                     ((item_i.arg_count == CNT_ONE) && adv))) begin
        on_v   = 1'b1;
        on_val = is_on;
      end
    end else if ((item_i.command_code == cfg_i.timing_code) &&
                 (item_i.frame_kind == KIND_MEASURE)) begin
      if (all_none) begin
        skip_fixed = 1'b1;
      end else begin
        tm_v = 1'b1;
        tm   = {item_i.arg_first, item_i.arg_second, item_i.arg_third};
      end
    end
    // fixed timing codes mean on and replace a timing report
    if (!skip_fixed && is_fixed) begin
      on_v   = 1'b1;
      on_val = 1'b1;
      tm_v   = 1'b0;
      tm     = '0;
    end

    lo  = state_i.lamp_on;
    dim = state_i.dim_level;
    req = REQ_NONE;
    if (on_v) begin
      lo  = on_val;
      req = (on_val && (state_i.dim_level == '0) && !item_i.point_to_point) ?
            REQ_START : REQ_CANCEL;
    end

    // ten-step levels and fault
    lv_v  = 1'b0;
    fault = 1'b0;
    if (normal && is_ten) begin
      dim  = ten_to_percent(item_i.command_code[3:0]);
      lv_v = 1'b1;
    end else if (normal && (item_i.command_code == cfg_i.fault_code)) begin
      fault = 1'b1;
    end

    // ten-step increment / decrement
    if (is_incdec && (item_i.arg_count == CNT_NONE)) begin
      if (lo) dim = ten_to_percent(step_new);
      else    lo  = 1'b1;
      lv_v = 1'b1;
    end

    // percent delta increment / decrement
    if (is_incdec && (item_i.arg_count == CNT_TWO) && adv) begin
      if (lo) dim = delta_dim;
      else    lo  = 1'b1;
      lv_v = 1'b1;
    end

    // percent status frame
    if ((item_i.command_code == CODE_PCT_STATUS) && meas_or_write && adv) begin
      if (item_i.arg_first == STATUS_OFFSET) begin
        lo     = 1'b0;
        on_v   = 1'b1;
        on_val = 1'b0;
      end else begin
        dim    = status_dim;
        lo     = 1'b1;
        on_v   = 1'b1;
        on_val = 1'b1;
        lv_v   = 1'b1;
      end
    end

    // hundred-step extras
    if (hun && normal && is_onoff && (item_i.arg_count == CNT_ONE)) begin
      on_v   = 1'b1;
      on_val = is_on;
    end
    sp_v = hun && (item_i.command_code == CODE_PCT_STATUS) &&
           (item_i.frame_kind == KIND_MEASURE) && lo;
  end

  // Result and next state
  always_comb begin
    result_o.on_valid      = on_v;
    result_o.on_value      = on_val;
    result_o.level_valid   = lv_v;
    result_o.level_value   = !lv_v ? 7'd0 : (hun ? dim : ten_times_ten(percent_to_ten(dim)));
    result_o.fault_seen    = fault;
    result_o.timing_valid  = tm_v;
    result_o.timing_hms    = tm;
    result_o.speed_valid   = sp_v;
    result_o.speed_value   = sp_v ? item_i.arg_second : 8'd0;
    result_o.level_request = req;
    state_o.dim_level      = dim;
    state_o.lamp_on        = lo;
  end

endmodule

### design/dimmer_frame_status_tracker.sv
// Top level: input register, frame decode, result register and dimmer state.
// Path: an accepted frame goes through the input register and the result register to the output.
// Throughput: one frame per cycle; a frame waits in the input register only
//   while the result register is full and not being taken.
// Reset: clears both valid flags, the dimmer level (unknown) and the on flag,
//   and loads the configuration defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module dimmer_frame_status_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dfst_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dfst_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  dfst_in_if.sink                             in_if,
  dfst_out_if.source                          out_if
);
  import dfst_pkg::*;

  dfst_cfg_t    cfg_q, cfg_d;
  dfst_state_t  state_q, state_d, state_next;
  dfst_item_t   item_q, item_d, item_in;
  dfst_result_t res_q, res_d, res_next;
  logic         in_valid_q, in_valid_d;
  logic         out_valid_q, out_valid_d;
  logic         in_ready, in_take, advance;

  // Handshake control
  assign advance  = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_ready = !in_valid_q || advance;
  assign in_take  = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  // Input item gather
  always_comb begin
    item_in.frame_kind     = in_if.frame_kind;
    item_in.command_code   = in_if.command_code;
    item_in.arg_count      = in_if.arg_count;
    item_in.arg_first      = in_if.arg_first;
    item_in.arg_second     = in_if.arg_second;
    item_in.arg_third      = in_if.arg_third;
    item_in.point_to_point = in_if.point_to_point;
  end

  // Frame decode
  dfst_step u_step (
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .result_o (res_next),
    .state_o  (state_next)
  );

  // Next-value logic
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ADVANCED: cfg_d.advanced_mode     = cfg_wdata_i[0];
        CFG_HUNDRED:  cfg_d.hundred_step_mode = cfg_wdata_i[0];
        CFG_ON_CODE:  cfg_d.on_code           = cfg_wdata_i;
        CFG_TIMING:   cfg_d.timing_code       = cfg_wdata_i;
        CFG_FAULT:    cfg_d.fault_code        = cfg_wdata_i;
        default:      cfg_d = cfg_q;
      endcase
    end

    in_valid_d = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    item_d     = in_take ? item_in : item_q;

    out_valid_d = advance ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_q);
    res_d       = advance ? res_next : res_q;
    state_d     = advance ? state_next : state_q;
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.advanced_mode     <= 1'b0;
      cfg_q.hundred_step_mode <= 1'b0;
      cfg_q.on_code           <= ON_CODE_RST;
      cfg_q.timing_code       <= TIMING_CODE_RST;
      cfg_q.fault_code        <= FAULT_CODE_RST;
      state_q                 <= '0;
      in_valid_q              <= 1'b0;
      out_valid_q             <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      state_q     <= state_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  // Result outputs
  assign out_if.valid         = out_valid_q;
  assign out_if.on_valid      = res_q.on_valid;
  assign out_if.on_value      = res_q.on_value;
  assign out_if.level_valid   = res_q.level_valid;
  assign out_if.level_value   = res_q.level_value;
  assign out_if.fault_seen    = res_q.fault_seen;
  assign out_if.timing_valid  = res_q.timing_valid;
  assign out_if.timing_hms    = res_q.timing_hms;
  assign out_if.speed_valid   = res_q.speed_valid;
  assign out_if.speed_value   = res_q.speed_value;
  assign out_if.level_request = res_q.level_request;

  // Stored level never leaves the percent range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.dim_level <= LEVEL_MAX)
    else $error("dimmer level above 100");

  // Dimmer state moves only when a frame goes through decode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("dimmer state changed without a frame");

  // An unreported on state reads as off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.on_valid |-> !res_q.on_value)
    else $error("on value set without on valid");

  // An empty result register never holds up the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

### tb/sv/tb.sv
// Self-checking testbench of the dimmer frame status tracker: directed and random frames.
`timescale 1ns / 1ps

module tb;
  import dfst_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RAND_PHASES   = 10;
  localparam int unsigned PHASE_FRAMES  = 100;

  // Upper percent bound of each ten-step level
  localparam int unsigned STEP_TOP [2:10] = '{4, 15, 25, 35, 45, 53, 67, 85, 100};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dfst_in_if  frame_ch ();
  dfst_out_if status_ch ();

  dimmer_frame_status_tracker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (frame_ch),
    .out_if      (status_ch)
  );

  // Shadow copy of the registers and the dimmer state
  dfst_cfg_t    cfg_m;
  logic [6:0]   level_m;
  logic         lit_m;

  dfst_result_t status_q [$];
  int unsigned  mismatches;
  int unsigned  frames_sent;
  int unsigned  statuses_seen;
  int unsigned  settings_used;
  bit           calm;

  // ---------------------------------------------------------------------------
  // Level tables
  // ---------------------------------------------------------------------------

  function automatic int step_of_pct(input logic [6:0] p);
    if (p == 7'd0) return 0;
    for (int s = 2; s <= 10; s++) begin
      if (p <= STEP_TOP[s]) return s;
    end
    return 10;
  endfunction

  function automatic logic [6:0] pct_of_step(input int s);
    if (s <= 2) return 7'd1;
    if (s == 9) return 7'd75;
    if (s >= 10) return 7'd100;
    return 7'((s - 2) * 10);
  endfunction

  function automatic logic [6:0] shown_level(input logic hun);
    if (hun) return level_m;
    return 7'(step_of_pct(level_m) * 10);
  endfunction

  // ---------------------------------------------------------------------------
  // Status predictor: updates the shadow state, returns the expected status
  // ---------------------------------------------------------------------------

  function automatic dfst_result_t predict_status(input dfst_item_t f);
    dfst_result_t r;
    logic         adv, hun, normal, meas_wr, incdec;
    logic         skip_fixed, want_on, want_tim, on_bit;
    logic [23:0]  hms;
    int           s;
    int           l;

    adv     = cfg_m.advanced_mode;
    hun     = adv & cfg_m.hundred_step_mode;
    normal  = f.frame_kind == KIND_NORMAL;
    meas_wr = (f.frame_kind == KIND_MEASURE) || (f.frame_kind == KIND_WRITE);
    incdec  = (f.command_code == CODE_LVL_UP) || (f.command_code == CODE_LVL_DN);
    r          = '0;
    skip_fixed = 1'b0;
    want_on    = 1'b0;
    want_tim   = 1'b0;
    on_bit     = 1'b0;
    hms        = '0;

    // on/off first, then variable timing
    if (f.command_code == cfg_m.on_code || f.command_code == CODE_OFF) begin
      if (normal && (f.arg_count == CNT_NONE || (f.arg_count == CNT_ONE && adv))) begin
        want_on = 1'b1;
        on_bit  = f.command_code == cfg_m.on_code;
      end
    end else if (f.command_code == cfg_m.timing_code) begin
      if (f.frame_kind == KIND_MEASURE) begin
        if (f.arg_first == ARG_NONE && f.arg_second == ARG_NONE && f.arg_third == ARG_NONE) begin
          skip_fixed = 1'b1;
        end else begin
          want_tim = 1'b1;
          hms      = {f.arg_first, f.arg_second, f.arg_third};
        end
      end
    end
    // fixed timing codes mean on and replace a timing report
    if (!skip_fixed && f.command_code >= FIX_TIME_FIRST &&
        f.command_code <= FIX_TIME_LAST) begin
      want_on  = 1'b1;
      want_tim = 1'b0;
      on_bit   = 1'b1;
    end
    r.on_valid     = want_on;
    r.on_value     = want_on & on_bit;
    r.timing_valid = want_tim;
    r.timing_hms   = want_tim ? hms : '0;

    // level request follows the on/off decode only
    if (want_on) begin
      lit_m = on_bit;
      r.level_request = (lit_m && level_m == 7'd0 && !f.point_to_point) ? REQ_START
                                                                         : REQ_CANCEL;
    end

    // ten-step levels win over the fault code
    if (normal) begin
      if (f.command_code >= DIMMER10_MIN && f.command_code <= DIMMER10_MAX) begin
        level_m       = pct_of_step(int'(f.command_code));
        r.level_valid = 1'b1;
        r.level_value = shown_level(hun);
      end else if (f.command_code == cfg_m.fault_code) begin
        r.fault_seen = 1'b1;
      end
    end

    // ten-step increment / decrement
    if (incdec && f.arg_count == CNT_NONE) begin
      if (lit_m) begin
        s = step_of_pct(level_m) + ((f.command_code == CODE_LVL_UP) ? 1 : -1);
        if (s < int'(STEP_MIN)) s = int'(STEP_MIN);
        if (s > int'(STEP_MAX)) s = int'(STEP_MAX);
        level_m = pct_of_step(s);
      end else begin
        lit_m = 1'b1;
      end
      r.level_valid = 1'b1;
      r.level_value = shown_level(hun);
    end

    // percent delta increment / decrement
    if (incdec && f.arg_count == CNT_TWO && adv) begin
      if (lit_m) begin
        l = int'(level_m) + ((f.command_code == CODE_LVL_UP) ? int'(f.arg_first)
                                                            : -int'(f.arg_first));
        if (l < int'(LEVEL_MIN)) l = int'(LEVEL_MIN);
        if (l > int'(LEVEL_MAX)) l = int'(LEVEL_MAX);
        level_m = 7'(l);
      end else begin
        lit_m = 1'b1;
      end
      r.level_valid = 1'b1;
      r.level_value = shown_level(hun);
    end

    // percent status: argument of exactly the offset means off
    if (f.command_code == CODE_PCT_STATUS && meas_wr && adv) begin
      l = int'(f.arg_first) - int'(STATUS_OFFSET);
      if (l == 0) begin
        lit_m      = 1'b0;
        r.on_valid = 1'b1;
        r.on_value = 1'b0;
      end else begin
        if (l < int'(LEVEL_MIN)) l = int'(LEVEL_MIN);
        if (l > int'(LEVEL_MAX)) l = int'(LEVEL_MAX);
        level_m       = 7'(l);
        lit_m         = 1'b1;
        r.on_valid    = 1'b1;
        r.on_value    = 1'b1;
        r.level_valid = 1'b1;
        r.level_value = shown_level(hun);
      end
    end

    // hundred-step reporting
    if (hun) begin
      if (r.level_valid) r.level_value = level_m;
      if (normal && (f.command_code == cfg_m.on_code || f.command_code == CODE_OFF) &&
          f.arg_count == CNT_ONE) begin
        r.on_valid = 1'b1;
        r.on_value = f.command_code == cfg_m.on_code;
      end
      if (f.command_code == CODE_PCT_STATUS && f.frame_kind == KIND_MEASURE && lit_m) begin
        r.speed_valid = 1'b1;
        r.speed_value = f.arg_second;
      end
      if (incdec && f.arg_count == CNT_TWO) begin
        r.level_valid = 1'b1;
        r.level_value = level_m;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------

  function automatic dfst_item_t bus_frame(input logic [1:0] kind, input logic [7:0] code,
                                           input logic [1:0] cnt, input logic [7:0] a0,
                                           input logic [7:0] a1, input logic [7:0] a2,
                                           input logic p2p);
    dfst_item_t f;
    f.frame_kind     = kind;
    f.command_code   = code;
    f.arg_count      = cnt;
    f.arg_first      = a0;
    f.arg_second     = a1;
    f.arg_third      = a2;
    f.point_to_point = p2p;
    return f;
  endfunction

  function automatic dfst_cfg_t cfg_of(input logic adv, input logic hun, input logic [7:0] on,
                                       input logic [7:0] tim, input logic [7:0] flt);
    dfst_cfg_t c;
    c.advanced_mode     = adv;
    c.hundred_step_mode = hun;
    c.on_code           = on;
    c.timing_code       = tim;
    c.fault_code        = flt;
    return c;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Send one item; returns right after the accepting edge with valid still high
  task automatic send_frame(input dfst_item_t f);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      frame_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    frame_ch.valid          <= 1'b1;
    frame_ch.frame_kind     <= f.frame_kind;
    frame_ch.command_code   <= f.command_code;
    frame_ch.arg_count      <= f.arg_count;
    frame_ch.arg_first      <= f.arg_first;
    frame_ch.arg_second     <= f.arg_second;
    frame_ch.arg_third      <= f.arg_third;
    frame_ch.point_to_point <= f.point_to_point;
    forever begin
      @(posedge clk_i);
      if (frame_ch.ready) break;
    end
    status_q.push_back(predict_status(f));
    frames_sent++;
  endtask

  // Stop sending and wait until every expected status has come out
  task automatic settle();
    @(negedge clk_i);
    frame_ch.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all five registers back to back
  task automatic apply_settings(input dfst_cfg_t c);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ADVANCED;
    cfg_wdata <= CFG_DATA_W'(c.advanced_mode);
    @(negedge clk_i);
    cfg_index <= CFG_HUNDRED;
    cfg_wdata <= CFG_DATA_W'(c.hundred_step_mode);
    @(negedge clk_i);
    cfg_index <= CFG_ON_CODE;
    cfg_wdata <= c.on_code;
    @(negedge clk_i);
    cfg_index <= CFG_TIMING;
    cfg_wdata <= c.timing_code;
    @(negedge clk_i);
    cfg_index <= CFG_FAULT;
    cfg_wdata <= c.fault_code;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    cfg_m = c;
    settings_used++;
  endtask

  function automatic logic [7:0] pick_code(input logic [7:0] dflt);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return dflt;
    if (r == 4) return 8'd0;
    if (r == 5) return 8'd255;
    if (r < 8) return 8'($urandom_range(0, 40));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic mostly();
    return $urandom_range(0, 9) != 0;
  endfunction

  // Random frame: mostly well-formed commands with random content, some noise
  function automatic dfst_item_t random_frame();
    dfst_item_t  f;
    int unsigned pick;
    f.frame_kind     = 2'($urandom_range(0, 3));
    f.command_code   = 8'($urandom_range(0, 255));
    f.arg_count      = 2'($urandom_range(0, 3));
    f.arg_first      = 8'($urandom_range(0, 255));
    f.arg_second     = 8'($urandom_range(0, 255));
    f.arg_third      = 8'($urandom_range(0, 255));
    f.point_to_point = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      f.command_code = $urandom_range(0, 1) ? cfg_m.on_code : CODE_OFF;
      if (mostly()) f.frame_kind = KIND_NORMAL;
      if (mostly()) f.arg_count = 2'($urandom_range(0, 1));
    end else if (pick < 20) begin
      f.command_code = 8'($urandom_range(FIX_TIME_FIRST, FIX_TIME_LAST));
    end else if (pick < 32) begin
      f.command_code = cfg_m.timing_code;
      if (mostly()) f.frame_kind = KIND_MEASURE;
      if ($urandom_range(0, 6) == 0) begin
        f.arg_first  = ARG_NONE;
        f.arg_second = ARG_NONE;
        f.arg_third  = ARG_NONE;
      end
    end else if (pick < 46) begin
      f.command_code = 8'($urandom_range(DIMMER10_MIN, DIMMER10_MAX));
      if (mostly()) f.frame_kind = KIND_NORMAL;
    end else if (pick < 70) begin
      f.command_code = $urandom_range(0, 1) ? CODE_LVL_UP : CODE_LVL_DN;
      if (pick < 58) begin
        if (mostly()) f.arg_count = CNT_NONE;
      end else begin
        if (mostly()) f.arg_count = CNT_TWO;
        if ($urandom_range(0, 9) < 7) f.arg_first = 8'($urandom_range(0, 30));
      end
    end else if (pick < 84) begin
      f.command_code = CODE_PCT_STATUS;
      if (mostly()) f.frame_kind = $urandom_range(0, 1) ? KIND_MEASURE : KIND_WRITE;
      if ($urandom_range(0, 3) != 0) f.arg_first = 8'($urandom_range(100, 200));
    end else if (pick < 90) begin
      f.command_code = cfg_m.fault_code;
      if (mostly()) f.frame_kind = KIND_NORMAL;
    end
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Status checker
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_status();
    dfst_result_t want;
    statuses_seen++;
    if (status_q.size() == 0) begin
      $error("status result with no frame pending");
      mismatches++;
    end else begin
      want = status_q.pop_front();
      check_field("on_valid", want.on_valid, status_ch.on_valid);
      check_field("on_value", want.on_value, status_ch.on_value);
      check_field("level_valid", want.level_valid, status_ch.level_valid);
      check_field("level_value", want.level_value, status_ch.level_value);
      check_field("fault_seen", want.fault_seen, status_ch.fault_seen);
      check_field("timing_valid", want.timing_valid, status_ch.timing_valid);
      check_field("timing_hms", want.timing_hms, status_ch.timing_hms);
      check_field("speed_valid", want.speed_valid, status_ch.speed_valid);
      check_field("speed_value", want.speed_value, status_ch.speed_value);
      check_field("level_request", want.level_request, status_ch.level_request);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && status_ch.valid && status_ch.ready) check_status();
  end

  // ---------------------------------------------------------------------------
  // Clock, result-side stalls and run limit
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    int unsigned run;
    int unsigned stall;
    status_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      status_ch.ready <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run - 1) @(negedge clk_i);
      stall = pick_gap();
      repeat (stall) begin
        @(negedge clk_i);
        status_ch.ready <= 1'b0;
      end
    end
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: on/off, level request, timing, levels, fault, ten-step inc/dec, advanced frames ignored
  task automatic test_reset_settings();
    send_frame(bus_frame(KIND_NORMAL, 8'd1, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b1));
    send_frame(bus_frame(KIND_NORMAL, CODE_OFF, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, 8'd1, CNT_NONE, 8'd255, 8'd255, 8'd255, 1'b0));
    send_frame(bus_frame(KIND_MEASURE, FIX_TIME_FIRST, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_MEASURE, 8'd2, CNT_NONE, 8'd1, 8'd2, 8'd3, 1'b0));
    send_frame(bus_frame(KIND_MEASURE, 8'd2, 2'd3, ARG_NONE, ARG_NONE, ARG_NONE, 1'b0));
    send_frame(bus_frame(KIND_MEASURE, 8'd2, 2'd3, 8'd0, 8'd0, 8'd0, 1'b1));
    send_frame(bus_frame(KIND_NORMAL, 8'd1, CNT_ONE, 8'd0, 8'd0, 8'd0, 1'b0));
    for (int c = DIMMER10_MIN; c <= DIMMER10_MAX; c++) begin
      send_frame(bus_frame(KIND_NORMAL, 8'(c), CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    end
    send_frame(bus_frame(KIND_NORMAL, 8'd19, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_MEASURE, 8'd19, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, CODE_LVL_UP, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_WRITE, CODE_LVL_DN, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_MEASURE, CODE_PCT_STATUS, CNT_ONE, 8'd150, 8'd9, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, CODE_OFF, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, CODE_LVL_UP, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, CODE_LVL_UP, CNT_TWO, 8'd40, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(2'd3, FIX_TIME_LAST, 2'd3, 8'd0, 8'd0, 8'd0, 1'b1));
    settle();
  endtask

  // Advanced mode in ten-step reporting: status frames, deltas, on with argument
  task automatic test_advanced_mode();
    apply_settings(cfg_of(1'b1, 1'b0, ON_CODE_RST, TIMING_CODE_RST, FAULT_CODE_RST));
    send_frame(bus_frame(KIND_MEASURE, CODE_PCT_STATUS, CNT_ONE, 8'd100, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_MEASURE, CODE_PCT_STATUS, CNT_ONE, 8'd150, 8'd7, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_WRITE, CODE_PCT_STATUS, CNT_ONE, 8'd99, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_WRITE, CODE_PCT_STATUS, CNT_ONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_MEASURE, CODE_PCT_STATUS, CNT_ONE, 8'd200, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_MEASURE, CODE_PCT_STATUS, CNT_ONE, 8'd255, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_WRITE, CODE_PCT_STATUS, CNT_ONE, 8'd101, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, CODE_LVL_UP, CNT_TWO, 8'd255, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, CODE_LVL_DN, CNT_TWO, 8'd255, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, CODE_LVL_DN, CNT_TWO, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, CODE_LVL_DN, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, CODE_OFF, CNT_ONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, CODE_LVL_UP, CNT_TWO, 8'd5, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, 8'd1, CNT_ONE, 8'd0, 8'd0, 8'd0, 1'b1));
    settle();
  endtask

  // Hundred-step reporting with advanced mode, then the hundred-step setting without it (ten-step reporting)
  task automatic test_hundred_mode();
    apply_settings(cfg_of(1'b1, 1'b1, ON_CODE_RST, TIMING_CODE_RST, FAULT_CODE_RST));
    send_frame(bus_frame(KIND_MEASURE, CODE_PCT_STATUS, CNT_TWO, 8'd155, 8'd200, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_WRITE, CODE_PCT_STATUS, CNT_TWO, 8'd120, 8'd33, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, CODE_LVL_UP, CNT_TWO, 8'd7, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, 8'd9, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, CODE_OFF, CNT_ONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, 8'd1, CNT_ONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_MEASURE, CODE_PCT_STATUS, CNT_TWO, 8'd100, 8'd255, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_MEASURE, CODE_PCT_STATUS, CNT_TWO, 8'd43, 8'd255, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, CODE_LVL_DN, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    settle();
    apply_settings(cfg_of(1'b0, 1'b1, ON_CODE_RST, TIMING_CODE_RST, FAULT_CODE_RST));
    send_frame(bus_frame(KIND_NORMAL, 8'd8, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, CODE_LVL_UP, CNT_TWO, 8'd9, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_MEASURE, CODE_PCT_STATUS, CNT_TWO, 8'd130, 8'd1, 8'd0, 1'b0));
    settle();
  endtask

  // Code collisions between on, off, timing, fixed timing, levels and fault
  task automatic test_code_clashes();
    apply_settings(cfg_of(1'b0, 1'b0, 8'd2, 8'd2, 8'd5));
    send_frame(bus_frame(KIND_NORMAL, 8'd2, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_MEASURE, 8'd2, CNT_NONE, 8'd4, 8'd5, 8'd6, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, 8'd5, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_MEASURE, CODE_OFF, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    settle();
    apply_settings(cfg_of(1'b1, 1'b0, 8'd0, FIX_TIME_FIRST, 8'd255));
    send_frame(bus_frame(KIND_NORMAL, CODE_OFF, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_MEASURE, FIX_TIME_FIRST, CNT_NONE, 8'd1, 8'd2, 8'd3, 1'b0));
    send_frame(bus_frame(KIND_MEASURE, FIX_TIME_FIRST, CNT_NONE,
                         ARG_NONE, ARG_NONE, ARG_NONE, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, 8'd255, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    settle();
    apply_settings(cfg_of(1'b1, 1'b1, 8'd255, 8'd0, 8'd0));
    send_frame(bus_frame(KIND_NORMAL, CODE_OFF, CNT_NONE, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(bus_frame(KIND_MEASURE, CODE_OFF, CNT_NONE, 8'd7, 8'd8, 8'd9, 1'b0));
    send_frame(bus_frame(KIND_NORMAL, 8'd255, CNT_ONE, 8'd0, 8'd0, 8'd0, 1'b0));
    settle();
  endtask

  // Random frames under a new register setting per phase, extremes first
  task automatic test_random_traffic();
    dfst_cfg_t c;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        c = cfg_of(1'b0, 1'b0, 8'd0, 8'd0, 8'd0);
      end else if (ph == 1) begin
        c = cfg_of(1'b1, 1'b1, 8'd255, 8'd255, 8'd255);
      end else begin
        c = cfg_of($urandom_range(0, 9) < 7, 1'($urandom_range(0, 1)),
                   pick_code(ON_CODE_RST), pick_code(TIMING_CODE_RST),
                   pick_code(FAULT_CODE_RST));
      end
      apply_settings(c);
      calm = (ph % 4) == 3;
      repeat (PHASE_FRAMES) send_frame(random_frame());
      settle();
      calm = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni                  = 1'b0;
    cfg_we                  = 1'b0;
    cfg_index               = '0;
    cfg_wdata               = '0;
    frame_ch.valid          = 1'b0;
    frame_ch.frame_kind     = '0;
    frame_ch.command_code   = '0;
    frame_ch.arg_count      = '0;
    frame_ch.arg_first      = '0;
    frame_ch.arg_second     = '0;
    frame_ch.arg_third      = '0;
    frame_ch.point_to_point = 1'b0;
    mismatches    = 0;
    frames_sent   = 0;
    statuses_seen = 0;
    settings_used = 0;
    calm          = 1'b0;
    cfg_m   = cfg_of(1'b0, 1'b0, ON_CODE_RST, TIMING_CODE_RST, FAULT_CODE_RST);
    level_m = 7'd0;
    lit_m   = 1'b0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_settings();
    test_advanced_mode();
    test_hundred_mode();
    test_code_clashes();
    test_random_traffic();

    $display("Sent %0d frames under %0d register settings plus reset values.",
             frames_sent, settings_used);
    $display("Checked %0d status results, %0d field mismatches.",
             statuses_seen, mismatches);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### dimmer_frame_status_tracker.f
design/dfst_pkg.sv
design/dfst_if.sv
design/dfst_step.sv
design/dimmer_frame_status_tracker.sv
tb/sv/tb.sv
